// ===== hw/rtl/drs_pkg.sv =====
// drs_pkg: sizes, item types, state encoding and key mapping for the double sorter
// shared by double_radix_sorter; depends on nothing
`default_nettype none

package drs_pkg;

  // capacity and digit geometry
  localparam int MAX_ITEMS   = 64;
  localparam int DIGIT_BITS  = 8;
  localparam int WORD_W      = 64;
  localparam int NUM_BUCKETS = 1 << DIGIT_BITS;
  localparam int NUM_PASSES  = (WORD_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int IDX_W       = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int PASS_W      = $clog2(NUM_PASSES);

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [DIGIT_BITS:0]   bsweep_t;
  typedef logic [PASS_W-1:0]     pass_t;

  // channel payloads
  typedef struct packed {
    logic [63:0] value_bits;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] sorted_bits;
    logic        last_res;
    logic        overflowed;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_t;

  // raw double bits to an unsigned order key
  function automatic word_t to_key(input word_t x);
    word_t k;
    if (x[WORD_W-1]) begin
      k = ~x;
    end else begin
      k = {1'b1, x[WORD_W-2:0]};
    end
    return k;
  endfunction

  // order key back to raw double bits
  function automatic word_t from_key(input word_t k);
    word_t x;
    if (k[WORD_W-1]) begin
      x = {1'b0, k[WORD_W-2:0]};
    end else begin
      x = ~k;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/double_radix_sorter.sv =====
// double_radix_sorter: lsd radix sort of ieee-754 double bit patterns over block memories
// depends on drs_pkg (types, sizes, key mapping)
//
//   channel | direction | signals                        | payload
//   --------+-----------+--------------------------------+--------------------------------
//   in      | input     | in_valid, in_ready, in_data    | value_bits, last
//   out     | output    | out_valid, out_ready, out_data | sorted_bits, last_res, overflowed
//
// items load while in_ready is high; an item marked last starts the sort of n held items.
// each of NUM_PASSES byte passes runs a counting sweep and a scatter sweep over the item
// memories plus an offset sweep over the bucket memory, whose single read port sets the
// pace. results leave one per cycle while out_ready is high. the clear state empties the
// bucket valid bits at once, as reset does, so no clearing pass is needed.
// out_ready low holds the current result; inputs are taken only while loading.
`default_nettype none

module double_radix_sorter (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  drs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output drs_pkg::out_item_t  out_data
);

  // sequencer and run state
  drs_pkg::state_t  state_r, state_nxt;
  drs_pkg::cnt_t    cnt_r;
  logic             ovf_r;
  drs_pkg::pass_t   pass_r;
  logic             src_sel_r;
  drs_pkg::cnt_t    i_r;
  drs_pkg::bsweep_t b_r;
  drs_pkg::cnt_t    run_r;
  drs_pkg::cnt_t    o_idx_r;

  // sweep pipeline
  logic             s1_vld_r;
  logic             s2_vld_r;
  drs_pkg::digit_t  s2_dig_r;
  drs_pkg::word_t   s2_key_r;
  logic             fwd_vld_r;
  drs_pkg::digit_t  fwd_dig_r;
  drs_pkg::cnt_t    fwd_val_r;
  logic             pf_vld_r;
  drs_pkg::digit_t  pf_dig_r;

  // memories
  drs_pkg::word_t   mem0 [drs_pkg::MAX_ITEMS];
  drs_pkg::word_t   mem1 [drs_pkg::MAX_ITEMS];
  drs_pkg::word_t   rd0_r, rd1_r;
  drs_pkg::cnt_t    bkt_mem [drs_pkg::NUM_BUCKETS];
  drs_pkg::cnt_t    bkt_rd_r;
  logic             bkt_rvld_r;
  logic [drs_pkg::NUM_BUCKETS-1:0] bkt_vld_r;

  // combinational controls
  logic             in_fire, out_fire, is_full, is_last;
  logic             sweeping, issue, sweep_done, pf_issue, pf_done, last_pass;
  logic             mem_re;
  drs_pkg::idx_t    mem_raddr;
  drs_pkg::word_t   s1_key;
  drs_pkg::digit_t  s1_dig;
  logic             bkt_re, bkt_we;
  drs_pkg::digit_t  bkt_raddr, bkt_waddr;
  drs_pkg::cnt_t    bkt_wdata;
  drs_pkg::cnt_t    s2_cnt, pf_cnt;
  logic             m0_we, m1_we;
  drs_pkg::idx_t    m0_waddr;
  drs_pkg::word_t   m0_wdata;

  // handshakes and run status
  always_comb begin
    in_ready   = (state_r == drs_pkg::ST_LOAD);
    out_valid  = (state_r == drs_pkg::ST_OUT_SHOW);
    in_fire    = in_valid && in_ready;
    out_fire   = out_valid && out_ready;
    is_full    = (cnt_r == drs_pkg::cnt_t'(drs_pkg::MAX_ITEMS));
    is_last    = ((o_idx_r + drs_pkg::cnt_t'(1)) == cnt_r);
    sweeping   = (state_r == drs_pkg::ST_COUNT) || (state_r == drs_pkg::ST_SCATTER);
    issue      = sweeping && (i_r < cnt_r);
    sweep_done = sweeping && (i_r == cnt_r) && !s1_vld_r && !s2_vld_r;
    pf_issue   = (state_r == drs_pkg::ST_PREFIX) && !b_r[drs_pkg::DIGIT_BITS];
    pf_done    = (state_r == drs_pkg::ST_PREFIX) && b_r[drs_pkg::DIGIT_BITS] && !pf_vld_r;
    last_pass  = (pass_r == drs_pkg::pass_t'(drs_pkg::NUM_PASSES - 1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drs_pkg::ST_LOAD: begin
        if (in_fire && in_data.last) state_nxt = drs_pkg::ST_CLEAR;
      end
      drs_pkg::ST_CLEAR: begin
        state_nxt = drs_pkg::ST_COUNT;
      end
      drs_pkg::ST_COUNT: begin
        if (sweep_done) state_nxt = drs_pkg::ST_PREFIX;
      end
      drs_pkg::ST_PREFIX: begin
        if (pf_done) state_nxt = drs_pkg::ST_SCATTER;
      end
      drs_pkg::ST_SCATTER: begin
        if (sweep_done) state_nxt = last_pass ? drs_pkg::ST_OUT_RD : drs_pkg::ST_CLEAR;
      end
      drs_pkg::ST_OUT_RD: begin
        state_nxt = drs_pkg::ST_OUT_SHOW;
      end
      drs_pkg::ST_OUT_SHOW: begin
        if (out_fire && is_last) state_nxt = drs_pkg::ST_LOAD;
      end
      default: begin
        state_nxt = drs_pkg::ST_LOAD;
      end
    endcase
  end

  // memory port controls and datapath
  always_comb begin
    // item memory read: sweep source or result readout
    mem_re    = 1'b0;
    mem_raddr = i_r[drs_pkg::IDX_W-1:0];
    if (issue) begin
      mem_re = 1'b1;
    end else if (state_r == drs_pkg::ST_OUT_RD) begin
      mem_re    = 1'b1;
      mem_raddr = o_idx_r[drs_pkg::IDX_W-1:0];
    end else if (out_fire && !is_last) begin
      mem_re    = 1'b1;
      mem_raddr = drs_pkg::idx_t'(o_idx_r + drs_pkg::cnt_t'(1));
    end

    // digit of the item leaving the source memory
    s1_key = src_sel_r ? rd1_r : rd0_r;
    s1_dig = drs_pkg::digit_t'(s1_key >> (int'(pass_r) * drs_pkg::DIGIT_BITS));

    // bucket read: sweep digit or offset sweep address
    bkt_re    = s1_vld_r || pf_issue;
    bkt_raddr = s1_vld_r ? s1_dig : b_r[drs_pkg::DIGIT_BITS-1:0];

    // current bucket value, forwarding the write made in the previous cycle
    if (fwd_vld_r && (fwd_dig_r == s2_dig_r)) begin
      s2_cnt = fwd_val_r;
    end else begin
      s2_cnt = bkt_rvld_r ? bkt_rd_r : '0;
    end
    pf_cnt = bkt_rvld_r ? bkt_rd_r : '0;

    // bucket write: increment during sweeps, exclusive offset during prefix
    bkt_we    = s2_vld_r || pf_vld_r;
    bkt_waddr = s2_vld_r ? s2_dig_r : pf_dig_r;
    bkt_wdata = s2_vld_r ? (s2_cnt + drs_pkg::cnt_t'(1)) : run_r;

    // item memory writes: load into mem0, scatter into the destination
    m1_we    = s2_vld_r && (state_r == drs_pkg::ST_SCATTER) && !src_sel_r;
    m0_we    = (s2_vld_r && (state_r == drs_pkg::ST_SCATTER) && src_sel_r)
               || (in_fire && !is_full);
    m0_waddr = in_ready ? cnt_r[drs_pkg::IDX_W-1:0] : s2_cnt[drs_pkg::IDX_W-1:0];
    m0_wdata = in_ready ? drs_pkg::to_key(in_data.value_bits) : s2_key_r;

    // result payload straight from the registered read data
    out_data.sorted_bits = drs_pkg::from_key(src_sel_r ? rd1_r : rd0_r);
    out_data.last_res    = is_last;
    out_data.overflowed  = ovf_r;
  end

  // item memories
  always_ff @(posedge clk) begin
    if (m0_we) begin
      mem0[m0_waddr] <= m0_wdata;
    end
    if (m1_we) begin
      mem1[s2_cnt[drs_pkg::IDX_W-1:0]] <= s2_key_r;
    end
    if (mem_re) begin
      rd0_r <= mem0[mem_raddr];
      rd1_r <= mem1[mem_raddr];
    end
  end

  // bucket memory
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rd_r   <= bkt_mem[bkt_raddr];
      bkt_rvld_r <= bkt_vld_r[bkt_raddr];
    end
  end

  // bucket valid bits, cleared at reset and at each pass start
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == drs_pkg::ST_CLEAR)) begin
      bkt_vld_r <= '0;
    end else if (bkt_we) begin
      bkt_vld_r[bkt_waddr] <= 1'b1;
    end
  end

  // sweep pipeline payload
  always_ff @(posedge clk) begin
    s2_dig_r  <= s1_dig;
    s2_key_r  <= s1_key;
    fwd_dig_r <= s2_dig_r;
    fwd_val_r <= bkt_wdata;
    pf_dig_r  <= b_r[drs_pkg::DIGIT_BITS-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= drs_pkg::ST_LOAD;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      pass_r    <= '0;
      src_sel_r <= 1'b0;
      i_r       <= '0;
      b_r       <= '0;
      run_r     <= '0;
      o_idx_r   <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      pf_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      s1_vld_r  <= issue;
      s2_vld_r  <= s1_vld_r;
      fwd_vld_r <= s2_vld_r;
      pf_vld_r  <= pf_issue;

      // loading and end of run
      if (in_fire) begin
        if (is_full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + drs_pkg::cnt_t'(1);
        end
        pass_r    <= '0;
        src_sel_r <= 1'b0;
      end else if (out_fire && is_last) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end

      // sweep item index
      if ((state_r == drs_pkg::ST_CLEAR) || pf_done) begin
        i_r <= '0;
      end else if (issue) begin
        i_r <= i_r + drs_pkg::cnt_t'(1);
      end

      // offset sweep over the buckets
      if ((state_r == drs_pkg::ST_COUNT) && sweep_done) begin
        b_r   <= '0;
        run_r <= '0;
      end else begin
        if (pf_issue) b_r <= b_r + drs_pkg::bsweep_t'(1);
        if (pf_vld_r) run_r <= run_r + pf_cnt;
      end

      // pass bookkeeping and ping-pong swap
      if ((state_r == drs_pkg::ST_SCATTER) && sweep_done) begin
        pass_r    <= pass_r + drs_pkg::pass_t'(1);
        src_sel_r <= !src_sel_r;
        o_idx_r   <= '0;
      end else if (out_fire && !is_last) begin
        o_idx_r <= o_idx_r + drs_pkg::cnt_t'(1);
      end
    end
  end

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  // overflow only once the buffer is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> is_full)
    else $error("overflow flagged below capacity");

  // a bucket never counts past the number of held items
  a_bkt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (bkt_wdata <= cnt_r))
    else $error("bucket count beyond item count");

  // the final result returns the block to loading with a fresh run
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_data.last_res) |=> (in_ready && (cnt_r == '0) && !ovf_r))
    else $error("run state not cleared after last result");

  // sweeps drain before the bucket offsets are built
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == drs_pkg::ST_PREFIX) |-> (!s1_vld_r && !s2_vld_r))
    else $error("sweep pipeline busy during offset sweep");

endmodule

`default_nettype wire
